/* hdl/seven_segment_scan_driver_top_assert.svh */
// Assertion macros for the seven-segment scan driver
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSD_ASSERT(lbl, prop, msg)
`define SSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/ssd_pkg.sv */
// Shared types, constants and decode functions of the seven-segment scan driver
package ssd_pkg;

  localparam logic       KIND_LOAD  = 1'b0;
  localparam logic       KIND_TICK  = 1'b1;
  localparam logic [13:0] MAX_NUMBER = 14'd9999;
  // floor(n * 5243 / 2^19) == floor(n / 100) for every 14-bit n
  localparam logic [13:0] RECIP_100  = 14'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam int          NUM_DIGITS = 4;

  typedef logic [3:0] digit_t;
  typedef logic [1:0] pos_t;
  typedef logic [6:0] pair_t;

  // Classified item handed from the front part to the back part
  typedef struct packed {
    logic  kind;
    logic  ok;
    pair_t hi;  // number / 100
    pair_t lo;  // number % 100
  } q_item_t;

  localparam digit_t RESET_DIGIT [NUM_DIGITS] = '{4'd7, 4'd8, 4'd3, 4'd2};

  function automatic logic [7:0] seg_decode(input digit_t d);
    logic [7:0] pat;
    unique case (d)
      4'd0:    pat = 8'h03;
      4'd1:    pat = 8'h9F;
      4'd2:    pat = 8'h25;
      4'd3:    pat = 8'h0D;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h49;
      4'd6:    pat = 8'h41;
      4'd7:    pat = 8'h1F;
      4'd8:    pat = 8'h01;
      4'd9:    pat = 8'h19;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

  // Split a value below 100 into {tens, ones}
  function automatic logic [7:0] split_tens(input pair_t x);
    digit_t tens;
    pair_t  ones;
    tens = '0;
    for (int k = 1; k < 10; k++) begin
      tens = tens + digit_t'(x >= pair_t'(10 * k));
    end
    ones = x - ({3'b0, tens} << 3) - ({3'b0, tens} << 1);
    return {tens, ones[3:0]};
  endfunction

endpackage

/* hdl/ssd_if.sv */
// Channel interfaces: input items and result items
interface ssd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [13:0] number;
  modport source (output valid, kind, number, input ready);
  modport sink   (input valid, kind, number, output ready);
endinterface

interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       pattern_valid;
  logic [1:0] digit_position;
  logic       digit_line_bit;
  logic [7:0] segment_pattern;
  modport source (output valid, accepted, pattern_valid, digit_position, digit_line_bit,
                  segment_pattern, input ready);
  modport sink   (input valid, accepted, pattern_valid, digit_position, digit_line_bit,
                  segment_pattern, output ready);
endinterface

/* hdl/ssd_front.sv */
// Front part: accept items, range check, split number into hundreds pairs
module ssd_front (
  input  logic            clk,
  input  logic            rst_n,
  ssd_in_if.sink          in_ch,
  output logic            f_valid,
  input  logic            f_ready,
  output ssd_pkg::q_item_t f_item
);

  logic        f_valid_r, f_valid_nxt;
  logic        f_kind_r;
  logic        f_ok_r;
  logic [6:0]  f_hi_r;
  logic [13:0] f_num_r;
  logic [26:0] prod;
  logic [13:0] hi100;

  assign in_ch.ready = !f_valid_r || f_ready;
  assign prod = 27'(in_ch.number) * 27'(ssd_pkg::RECIP_100);

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      f_valid_nxt = 1'b1;
    end else if (f_ready) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      f_kind_r <= in_ch.kind;
      f_ok_r   <= (in_ch.number <= ssd_pkg::MAX_NUMBER);
      f_hi_r   <= prod[ssd_pkg::RECIP_SHIFT +: 7];
      f_num_r  <= in_ch.number;
    end
  end

  // hi * 100 by shift and add
  assign hi100 = ({7'b0, f_hi_r} << 6) + ({7'b0, f_hi_r} << 5) + ({7'b0, f_hi_r} << 2);

  always_comb begin
    f_item.kind = f_kind_r;
    f_item.ok   = f_ok_r;
    f_item.hi   = f_hi_r;
    f_item.lo   = 7'(f_num_r - hi100);
  end

  assign f_valid = f_valid_r;

endmodule

/* hdl/ssd_queue.sv */
// Two-entry queue between the front and back parts
module ssd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  ssd_pkg::q_item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ssd_pkg::q_item_t pop_item
);

  `include "seven_segment_scan_driver_top_assert.svh"

  ssd_pkg::q_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `SSD_ASSERT(a_q_depth, cnt_r != 2'd3, "queue count beyond depth")
  `SSD_ASSERT(a_q_ptrs, (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r), "queue pointers disagree with count")

endmodule

/* hdl/ssd_back.sv */
// Back part: digit store, scan position and registered result
module ssd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  ssd_pkg::q_item_t q_item,
  ssd_out_if.source        out_ch
);

  `include "seven_segment_scan_driver_top_assert.svh"

  ssd_pkg::digit_t digit_r [ssd_pkg::NUM_DIGITS];
  ssd_pkg::pos_t   scan_r, scan_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accepted_r, accepted_nxt;
  logic            pvalid_r, pvalid_nxt;
  ssd_pkg::pos_t   pos_r, pos_nxt;
  logic            line_r, line_nxt;
  logic [7:0]      pat_r, pat_nxt;
  logic            pop, store_wr;
  logic [7:0]      hi_split, lo_split;

  assign q_ready  = !out_valid_r || out_ch.ready;
  assign pop      = q_valid && q_ready;
  assign store_wr = pop && (q_item.kind == ssd_pkg::KIND_LOAD) && q_item.ok;
  assign hi_split = ssd_pkg::split_tens(q_item.hi);
  assign lo_split = ssd_pkg::split_tens(q_item.lo);

  always_comb begin
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    accepted_nxt  = accepted_r;
    pvalid_nxt    = pvalid_r;
    pos_nxt       = pos_r;
    line_nxt      = line_r;
    pat_nxt       = pat_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      if (q_item.kind == ssd_pkg::KIND_TICK) begin
        // Advance first, then show the digit at the new position
        scan_nxt     = scan_r + 2'd1;
        accepted_nxt = 1'b0;
        pvalid_nxt   = 1'b1;
        pos_nxt      = scan_nxt;
        line_nxt     = (scan_nxt == 2'd0);
        pat_nxt      = ssd_pkg::seg_decode(digit_r[scan_nxt]);
        if (scan_nxt == 2'd1 || scan_nxt == 2'd2) begin
          pat_nxt[0] = 1'b0;
        end
      end else begin
        accepted_nxt = q_item.ok;
        pvalid_nxt   = 1'b0;
        pos_nxt      = 2'd0;
        line_nxt     = 1'b0;
        pat_nxt      = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= 2'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
        digit_r[i] <= ssd_pkg::RESET_DIGIT[i];
      end
    end else begin
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
      if (store_wr) begin
        digit_r[0] <= lo_split[3:0];
        digit_r[1] <= lo_split[7:4];
        digit_r[2] <= hi_split[3:0];
        digit_r[3] <= hi_split[7:4];
      end
    end
  end

  always_ff @(posedge clk) begin
    accepted_r <= accepted_nxt;
    pvalid_r   <= pvalid_nxt;
    pos_r      <= pos_nxt;
    line_r     <= line_nxt;
    pat_r      <= pat_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.accepted        = accepted_r;
  assign out_ch.pattern_valid   = pvalid_r;
  assign out_ch.digit_position  = pos_r;
  assign out_ch.digit_line_bit  = line_r;
  assign out_ch.segment_pattern = pat_r;

  `SSD_ASSERT(a_scan_step, (pop && q_item.kind == ssd_pkg::KIND_TICK) |=> (scan_r == $past(scan_r) + 2'd1), "tick did not advance scan position")
  `SSD_ASSERT(a_scan_hold, (!pop || q_item.kind == ssd_pkg::KIND_LOAD) |=> $stable(scan_r), "scan position moved without a tick")
  `SSD_ASSERT(a_line_bit, (out_valid_r && pvalid_r) |-> (line_r == (pos_r == 2'd0)), "digit line bit disagrees with position")
  `SSD_ASSERT(a_digits_dec, (digit_r[0] <= 4'd9) && (digit_r[1] <= 4'd9) && (digit_r[2] <= 4'd9) && (digit_r[3] <= 4'd9), "stored digit is not decimal")

endmodule

/* hdl/seven_segment_scan_driver_top.sv */
// Path: an accepted item passes the front register, the two-entry queue and the result register to out_ch.
// Throughput: one item per cycle if out_ch is ready; the front register, the queue and the result register
//   each move one item a cycle, and the number split (one 14x14 constant multiply) sets the front path.
// Reset (rst_n low, synchronous): pipeline and queue empty, scan position 0, digits 7, 8, 3, 2.
// No warm-up pass: in_ch.ready is high as soon as reset is released.
module seven_segment_scan_driver_top (
  input logic        clk,
  input logic        rst_n,
  ssd_in_if.sink     in_ch,
  ssd_out_if.source  out_ch
);

  // Front -> queue: classified item with the hundreds split already done
  logic             f_valid;
  logic             f_ready;
  ssd_pkg::q_item_t f_item;

  // Queue -> back
  logic             q_valid;
  logic             q_ready;
  ssd_pkg::q_item_t q_item;

  // Accept items, check the load range and split the number into number/100 and number%100
  ssd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_item  (f_item)
  );

  // Decouple the two parts so a stalled result side does not stop the front at once
  ssd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Write decimal digits on in-range loads, advance the scan and decode segments on ticks
  ssd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );

endmodule
